/* rtl/mbp_pkg.sv */
// Shared types, constants and the message classifier of the MIDI byte stream parser.
package mbp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 2;
  localparam int unsigned ClassW   = 4;
  localparam int unsigned EnableW  = 12;
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] SysMask     = 8'hF0;
  localparam logic [ByteW-1:0] StSysexBeg  = 8'hF0;
  localparam logic [ByteW-1:0] StQframe    = 8'hF1;
  localparam logic [ByteW-1:0] StSongPos   = 8'hF2;
  localparam logic [ByteW-1:0] StSongSel   = 8'hF3;
  localparam logic [ByteW-1:0] StTune      = 8'hF6;
  localparam logic [ByteW-1:0] StSysexEnd  = 8'hF7;
  localparam logic [ByteW-1:0] StRealtime  = 8'hF8;
  localparam logic [ByteW-1:0] HiNoteOff   = 8'h80;
  localparam logic [ByteW-1:0] HiNoteOn    = 8'h90;
  localparam logic [ByteW-1:0] HiAftertch  = 8'hA0;
  localparam logic [ByteW-1:0] HiCc        = 8'hB0;
  localparam logic [ByteW-1:0] HiProg      = 8'hC0;
  localparam logic [ByteW-1:0] HiPressure  = 8'hD0;
  localparam logic [ByteW-1:0] HiBend      = 8'hE0;

  localparam logic [ClassW-1:0] ClsCc        = 4'd0;
  localparam logic [ClassW-1:0] ClsNoteOn    = 4'd1;
  localparam logic [ClassW-1:0] ClsNoteOff   = 4'd2;
  localparam logic [ClassW-1:0] ClsAftertch  = 4'd3;
  localparam logic [ClassW-1:0] ClsBend      = 4'd4;
  localparam logic [ClassW-1:0] ClsSongPos   = 4'd5;
  localparam logic [ClassW-1:0] ClsProg      = 4'd6;
  localparam logic [ClassW-1:0] ClsPressure  = 4'd7;
  localparam logic [ClassW-1:0] ClsSongSel   = 4'd8;
  localparam logic [ClassW-1:0] ClsQframe    = 4'd9;
  localparam logic [ClassW-1:0] ClsRealtime  = 4'd10;
  localparam logic [ClassW-1:0] ClsTune      = 4'd11;
  localparam logic [ClassW-1:0] ClsOther     = 4'd12;

  localparam logic [LenW-1:0] Len1 = 2'd1;
  localparam logic [LenW-1:0] Len2 = 2'd2;
  localparam logic [LenW-1:0] Len3 = 2'd3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_TWO   = 2'd1,
    MODE_THREE = 2'd2,
    MODE_SYSEX = 2'd3
  } mode_t;

  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [ByteW-1:0] b2;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b0;
  } msg_t;

  localparam int unsigned MsgW = $bits(msg_t);

  function automatic logic [ClassW-1:0] classify(input logic [LenW-1:0] len,
                                                 input logic [ByteW-1:0] b0);
    logic [ByteW-1:0] hi;
    logic [ClassW-1:0] cls;
    hi  = b0 & SysMask;
    cls = ClsOther;
    case (len)
      Len3: begin
        if (hi == HiCc) cls = ClsCc;
        else if (hi == HiNoteOn) cls = ClsNoteOn;
        else if (hi == HiNoteOff) cls = ClsNoteOff;
        else if (hi == HiAftertch) cls = ClsAftertch;
        else if (hi == HiBend) cls = ClsBend;
        else if (b0 == StSongPos) cls = ClsSongPos;
      end
      Len2: begin
        if (hi == HiProg) cls = ClsProg;
        else if (hi == HiPressure) cls = ClsPressure;
        else if (b0 == StSongSel) cls = ClsSongSel;
        else if (b0 == StQframe) cls = ClsQframe;
      end
      Len1: begin
        if (b0 >= StRealtime) cls = ClsRealtime;
        else if (b0 == StTune) cls = ClsTune;
      end
      default: cls = ClsOther;
    endcase
    return cls;
  endfunction

endpackage

/* rtl/mbp_front.sv */
// Front end: byte parser that tracks mode, count and buffer and assembles messages.
module mbp_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [mbp_pkg::ByteW-1:0]   byte_in,
  output logic                        push,
  output mbp_pkg::msg_t               msg
);

  mbp_pkg::mode_t            mode_r, mode_nxt;
  logic [1:0]                cnt_r, cnt_nxt;
  logic [mbp_pkg::ByteW-1:0] buf_r [3];
  logic [mbp_pkg::ByteW-1:0] buf_nxt [3];
  logic [mbp_pkg::ByteW-1:0] hi;
  logic [1:0]                cnt_inc;
  mbp_pkg::mode_t            dmode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mbp_pkg::MODE_IDLE;
      cnt_r  <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        buf_r[i] <= '0;
      end
    end else begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      for (int i = 0; i < 3; i++) begin
        buf_r[i] <= buf_nxt[i];
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    for (int i = 0; i < 3; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    push    = 1'b0;
    msg     = '0;
    hi      = byte_in & mbp_pkg::SysMask;
    cnt_inc = cnt_r + 2'd1;
    dmode   = (cnt_r == 2'd3) ? mbp_pkg::MODE_IDLE : mode_r;
    if (accept) begin
      if (byte_in >= mbp_pkg::StRealtime) begin
        push   = 1'b1;
        msg.len = mbp_pkg::Len1;
        msg.b0  = byte_in;
      end else if (byte_in[7]) begin
        if (byte_in == mbp_pkg::StSysexEnd) begin
          mode_nxt = mbp_pkg::MODE_IDLE;
          cnt_nxt  = 2'd0;
          push     = 1'b1;
          if (mode_r == mbp_pkg::MODE_SYSEX && cnt_r <= 2'd2) begin
            for (int i = 0; i < 3; i++) begin
              if (cnt_r == 2'(i)) buf_nxt[i] = byte_in;
            end
            msg.len = cnt_inc;
            msg.b0  = buf_nxt[0];
            msg.b1  = (cnt_inc >= mbp_pkg::Len2) ? buf_nxt[1] : '0;
            msg.b2  = (cnt_inc >= mbp_pkg::Len3) ? buf_nxt[2] : '0;
          end else begin
            msg.len = mbp_pkg::Len1;
            msg.b0  = byte_in;
          end
        end else begin
          buf_nxt[0] = byte_in;
          cnt_nxt    = 2'd1;
          if (hi == mbp_pkg::HiNoteOff || hi == mbp_pkg::HiNoteOn ||
              hi == mbp_pkg::HiAftertch || hi == mbp_pkg::HiCc ||
              hi == mbp_pkg::HiBend || byte_in == mbp_pkg::StSongPos) begin
            mode_nxt = mbp_pkg::MODE_THREE;
          end else if (hi == mbp_pkg::HiProg || hi == mbp_pkg::HiPressure ||
                       byte_in == mbp_pkg::StQframe ||
                       byte_in == mbp_pkg::StSongSel) begin
            mode_nxt = mbp_pkg::MODE_TWO;
          end else if (byte_in == mbp_pkg::StSysexBeg) begin
            mode_nxt = mbp_pkg::MODE_SYSEX;
          end else begin
            mode_nxt = mbp_pkg::MODE_IDLE;
            cnt_nxt  = 2'd0;
            if (byte_in == mbp_pkg::StTune) begin
              push    = 1'b1;
              msg.len = mbp_pkg::Len1;
              msg.b0  = byte_in;
            end
          end
        end
      end else begin
        mode_nxt = dmode;
        if (dmode != mbp_pkg::MODE_IDLE) begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == 2'(i)) buf_nxt[i] = byte_in;
          end
          cnt_nxt = cnt_inc;
          if (cnt_inc == 2'd3) begin
            if (dmode != mbp_pkg::MODE_SYSEX) mode_nxt = mbp_pkg::MODE_IDLE;
            cnt_nxt = 2'd0;
            push    = 1'b1;
            msg.len = mbp_pkg::Len3;
            msg.b0  = buf_nxt[0];
            msg.b1  = buf_nxt[1];
            msg.b2  = buf_nxt[2];
          end else if (cnt_inc == 2'd2) begin
            if (dmode == mbp_pkg::MODE_TWO) begin
              mode_nxt = mbp_pkg::MODE_IDLE;
              cnt_nxt  = 2'd0;
              push     = 1'b1;
              msg.len  = mbp_pkg::Len2;
              msg.b0   = buf_nxt[0];
              msg.b1   = buf_nxt[1];
            end
          end else if (dmode != mbp_pkg::MODE_SYSEX) begin
            mode_nxt = mbp_pkg::MODE_IDLE;
          end
        end
      end
    end
  end

endmodule

/* rtl/mbp_queue.sv */
// Short message queue between the parser and the output stage.
module mbp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mbp_pkg::msg_t wr_msg,
  input  logic          pop,
  output mbp_pkg::msg_t rd_msg,
  output logic          not_empty,
  output logic          not_full
);

  mbp_pkg::msg_t                 mem_r [mbp_pkg::QDepth];
  logic [mbp_pkg::QPtrW-1:0]     wr_ptr_r;
  logic [mbp_pkg::QPtrW-1:0]     rd_ptr_r;
  logic [mbp_pkg::QCntW-1:0]     cnt_r;

  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != mbp_pkg::QCntW'(mbp_pkg::QDepth));
  assign rd_msg    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_msg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == mbp_pkg::QPtrW'(mbp_pkg::QDepth - 1)) ? '0 :
                    wr_ptr_r + mbp_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == mbp_pkg::QPtrW'(mbp_pkg::QDepth - 1)) ? '0 :
                    rd_ptr_r + mbp_pkg::QPtrW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + mbp_pkg::QCntW'(1);
        2'b01:   cnt_r <= cnt_r - mbp_pkg::QCntW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/mbp_back.sv */
// Back end: classifies queued messages, applies the enable mask and holds the output beat.
module mbp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write,
  input  logic [mbp_pkg::EnableW-1:0]   cfg_enable,
  input  logic                          q_not_empty,
  input  mbp_pkg::msg_t                 q_msg,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mbp_pkg::msg_t                 out_msg,
  output logic [mbp_pkg::ClassW-1:0]    out_class,
  output logic                          out_claimed
);

  logic [mbp_pkg::EnableW-1:0] enable_r;
  logic                        valid_r;
  mbp_pkg::msg_t               msg_r;
  logic [mbp_pkg::ClassW-1:0]  class_r;
  logic                        claimed_r;
  logic [mbp_pkg::ClassW-1:0]  cls;
  logic [15:0]                 enable_ext;
  logic                        load;

  assign load       = !valid_r || out_ready;
  assign q_pop      = load && q_not_empty;
  assign cls        = mbp_pkg::classify(q_msg.len, q_msg.b0);
  assign enable_ext = 16'(enable_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (cfg_write) enable_r <= cfg_enable;
      if (load) valid_r <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      msg_r     <= q_msg;
      class_r   <= cls;
      claimed_r <= (cls < mbp_pkg::ClsOther) && enable_ext[cls];
    end
  end

  assign out_valid   = valid_r;
  assign out_msg     = msg_r;
  assign out_class   = class_r;
  assign out_claimed = claimed_r;

endmodule

/* rtl/midi_byte_stream_parser.sv */
// Top level of the MIDI byte stream parser.
// Bytes enter on the in_ stream, one per beat; a status byte has bit 7 set.
// Assembled messages of one to three bytes leave on the out_ stream with
// their class and claimed flag in out_tuser.
// The cfg_ channel writes the 12-bit handler enable mask; it is always ready
// and is meant to be written while the parser holds no pending message.
// A byte that completes a message passes through the queue and then the
// output register before it appears on the output.
// Throughput is one byte per cycle while the queue is not full.
// Realtime bytes are forwarded at once and leave the parse state untouched.
// A two-entry queue sits between parser and output register, so in_tready
// stays high while a finished message waits for the receiver.
// When the receiver stalls, the output beat holds and the queue fills;
// in_tready drops once the queue is full.
// Synchronous reset returns the parser to idle, clears the byte buffer,
// empties the queue and clears the enable mask.
module midi_byte_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] midi_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] msg_length, [9:2] first_byte,
                                  // [17:10] second_byte, [25:18] third_byte
  output logic [4:0]  out_tuser,  // [3:0] msg_class, [4] claimed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  logic                         accept;
  logic                         push;
  mbp_pkg::msg_t                f_msg;
  mbp_pkg::msg_t                q_msg;
  logic                         q_pop;
  logic                         q_not_empty;
  logic                         q_not_full;
  mbp_pkg::msg_t                o_msg;
  logic [mbp_pkg::ClassW-1:0]   o_class;
  logic                         o_claimed;

  assign in_tready = q_not_full;
  assign accept    = in_tvalid && q_not_full;
  assign cfg_ready = 1'b1;

  mbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_tdata),
    .push    (push),
    .msg     (f_msg)
  );

  mbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_msg    (f_msg),
    .pop       (q_pop),
    .rd_msg    (q_msg),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  mbp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_write   (cfg_valid),
    .cfg_enable  (cfg_data),
    .q_not_empty (q_not_empty),
    .q_msg       (q_msg),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_msg     (o_msg),
    .out_class   (o_class),
    .out_claimed (o_claimed)
  );

  assign out_tdata = {6'd0, o_msg.b2, o_msg.b1, o_msg.b0, o_msg.len};
  assign out_tuser = {o_claimed, o_class};

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the MIDI byte stream parser with a scoreboard and stream drivers.
module tb;
  import mbp_pkg::*;

  localparam logic [ByteW-1:0] StUndefA   = 8'hF4;
  localparam logic [ByteW-1:0] StUndefB   = 8'hF5;
  localparam logic [ByteW-1:0] StSysReset = 8'hFF;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned NumDirected = 28;
  localparam logic [ByteW-1:0] DirBytes [NumDirected] = '{
    8'h05,
    HiNoteOn, 8'h00, 8'h7F,
    HiNoteOff | 8'h0F, 8'h7F, StRealtime, 8'h00,
    StTune, StSysReset, StUndefA, StUndefB, StSysexEnd,
    StSysexBeg, 8'h01, 8'h02, 8'h03, 8'h04, StSysexEnd,
    StSysexBeg, 8'h11, 8'h22, 8'h33, StSysexEnd,
    StSysexBeg, 8'h55, HiProg | 8'h03, 8'h7F
  };

  typedef struct packed {
    logic [LenW-1:0]   len;
    logic [ByteW-1:0]  b0;
    logic [ByteW-1:0]  b1;
    logic [ByteW-1:0]  b2;
    logic [ClassW-1:0] cls;
    logic              claimed;
  } midi_msg_t;

  class msg_scoreboard;
    mode_t              mode;
    logic [1:0]         count;
    logic [ByteW-1:0]   held [3];
    logic [EnableW-1:0] enable;
    midi_msg_t          expected_msgs [$];
    int                 errors;

    function new();
      mode   = MODE_IDLE;
      count  = '0;
      held   = '{default: '0};
      enable = '0;
      errors = 0;
    endfunction

    function logic [ClassW-1:0] class_of(input logic [LenW-1:0] len,
                                         input logic [ByteW-1:0] b0);
      logic [ByteW-1:0] hi;
      hi = b0 & SysMask;
      if (len == Len1) begin
        if (b0 >= StRealtime) return ClsRealtime;
        if (b0 == StTune) return ClsTune;
      end else if (len == Len2) begin
        if (hi == HiProg) return ClsProg;
        if (hi == HiPressure) return ClsPressure;
        if (b0 == StSongSel) return ClsSongSel;
        if (b0 == StQframe) return ClsQframe;
      end else if (len == Len3) begin
        case (hi)
          HiCc: return ClsCc;
          HiNoteOn: return ClsNoteOn;
          HiNoteOff: return ClsNoteOff;
          HiAftertch: return ClsAftertch;
          HiBend: return ClsBend;
          default: ;
        endcase
        if (b0 == StSongPos) return ClsSongPos;
      end
      return ClsOther;
    endfunction

    function void push_msg(input logic [LenW-1:0] len, input logic [ByteW-1:0] b0,
                           input logic [ByteW-1:0] b1, input logic [ByteW-1:0] b2);
      midi_msg_t m;
      m.len     = len;
      m.b0      = b0;
      m.b1      = (len >= Len2) ? b1 : '0;
      m.b2      = (len == Len3) ? b2 : '0;
      m.cls     = class_of(len, b0);
      m.claimed = (m.cls < ClsOther) ? enable[m.cls] : 1'b0;
      expected_msgs.push_back(m);
    endfunction

    // Returns 1 when the byte is a data byte that the idle parser drops.
    function bit accept_byte(input logic [ByteW-1:0] b);
      logic [1:0] n;
      if (b >= StRealtime) begin
        push_msg(Len1, b, '0, '0);
        return 1'b0;
      end
      if (b[7]) begin
        if (b == StSysexEnd) begin
          if (mode == MODE_SYSEX && count <= 2'd2) begin
            n = count;
            held[n] = b;
            mode = MODE_IDLE;
            count = '0;
            push_msg(LenW'(n + 2'd1), held[0], held[1], held[2]);
          end else begin
            mode = MODE_IDLE;
            count = '0;
            push_msg(Len1, b, '0, '0);
          end
          return 1'b0;
        end
        held[0] = b;
        count = 2'd1;
        case (b & SysMask)
          HiNoteOff, HiNoteOn, HiAftertch, HiCc, HiBend: mode = MODE_THREE;
          HiProg, HiPressure: mode = MODE_TWO;
          default: begin
            case (b)
              StSongPos: mode = MODE_THREE;
              StQframe, StSongSel: mode = MODE_TWO;
              StSysexBeg: mode = MODE_SYSEX;
              StTune: begin
                mode = MODE_IDLE;
                count = '0;
                push_msg(Len1, b, '0, '0);
              end
              default: begin
                mode = MODE_IDLE;
                count = '0;
              end
            endcase
          end
        endcase
        return 1'b0;
      end
      if (count > 2'd2) mode = MODE_IDLE;
      if (mode == MODE_IDLE) return 1'b1;
      held[count] = b;
      count = count + 2'd1;
      if (count == 2'd3) begin
        if (mode != MODE_SYSEX) mode = MODE_IDLE;
        count = '0;
        push_msg(Len3, held[0], held[1], held[2]);
      end else if (count == 2'd2) begin
        if (mode == MODE_TWO) begin
          mode = MODE_IDLE;
          count = '0;
          push_msg(Len2, held[0], held[1], '0);
        end
      end else if (mode != MODE_SYSEX) begin
        mode = MODE_IDLE;
      end
      return 1'b0;
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void compare_msg(input logic [31:0] data, input logic [4:0] user);
      midi_msg_t m;
      if (expected_msgs.size() == 0) begin
        errors++;
        $display("%0t: beat expected none actual data 0x%h user 0x%h", $time, data, user);
        return;
      end
      m = expected_msgs.pop_front();
      check_field("msg_length", m.len, data[1:0]);
      check_field("first_byte", m.b0, data[9:2]);
      check_field("second_byte", m.b1, data[17:10]);
      check_field("third_byte", m.b2, data[25:18]);
      check_field("tdata_pad", 0, data[31:26]);
      check_field("msg_class", m.cls, user[3:0]);
      check_field("claimed", m.claimed, user[4]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [4:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_data;

  msg_scoreboard sb = new();
  int send_idle_pct;
  int recv_stall_pct;
  int useful_beats;
  int unsigned cycles;
  bit hold_active;
  event hold_go;

  midi_byte_stream_parser DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  always begin
    @(hold_go);
    hold_active = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    hold_active = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (!sb.accept_byte(in_tdata)) useful_beats++;
      end
      if (out_tvalid && out_tready) sb.compare_msg(out_tdata, out_tuser);
    end
  end

  function automatic logic [ByteW-1:0] rand_data();
    case ($urandom_range(9))
      0: return 8'h00;
      1: return 8'h7F;
      default: return ByteW'($urandom_range(127));
    endcase
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic put(input logic [ByteW-1:0] b);
    if ($urandom_range(99) < 6) send_byte(ByteW'($urandom_range(255, 248)));
    send_byte(b);
  endtask

  task automatic write_enable(input logic [EnableW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.enable = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_msgs.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic send_random_message();
    int kind;
    int n;
    logic [ByteW-1:0] st;
    kind = $urandom_range(99);
    if (kind < 45) begin
      st = {4'($urandom_range(14, 8)), 4'($urandom_range(15))};
      n = ((st & SysMask) == HiProg || (st & SysMask) == HiPressure) ? 1 : 2;
      put(st);
      repeat (n) put(rand_data());
    end else if (kind < 55) begin
      case ($urandom_range(2))
        0: st = StQframe;
        1: st = StSongSel;
        default: st = StSongPos;
      endcase
      n = (st == StSongPos) ? 2 : 1;
      put(st);
      repeat (n) put(rand_data());
    end else if (kind < 70) begin
      put(StSysexBeg);
      repeat ($urandom_range(8)) put(rand_data());
      if ($urandom_range(9) != 0) put(StSysexEnd);
    end else if (kind < 75) begin
      put(StTune);
    end else if (kind < 80) begin
      case ($urandom_range(2))
        0: put(StSysexEnd);
        1: put(StUndefA);
        default: put(StUndefB);
      endcase
    end else if (kind < 90) begin
      put(ByteW'($urandom_range(247, 128)));
      repeat ($urandom_range(1)) put(rand_data());
    end else begin
      repeat ($urandom_range(3, 1)) put(ByteW'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct,
                           input logic [EnableW-1:0] en, input int beats);
    int stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_enable(en);
    stop_at = useful_beats + beats;
    while (useful_beats < stop_at) send_random_message();
    send_byte(StUndefA);
    in_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    useful_beats   = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_enable(12'hFFF);
    for (int i = 0; i < NumDirected; i++) send_byte(DirBytes[i]);
    in_tvalid <= 1'b0;
    wait_drained();

    run_phase(0, 0, 12'h000, 300);
    run_phase(84, 0, EnableW'($urandom_range(4095)), 300);
    run_phase(0, 84, 12'hA5C, 300);
    run_phase(19, 19, EnableW'($urandom_range(4095)), 300);

    // The receiver holds off while bytes keep coming, then the sender waits for a clean drain and sends a second burst.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_enable(12'h555);
    -> hold_go;
    repeat (12) send_random_message();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (sb.expected_msgs.size() != 0) @(negedge clk);
    repeat (12) send_random_message();
    in_tvalid <= 1'b0;
    wait_drained();

    if (sb.errors == 0 && sb.expected_msgs.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
